FILE: rtl/bounded_double_ended_queue_macros.svh
// Assertion macros for the bounded double-ended queue.
// Included by the top level; no other dependencies.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_MACROS_SVH
`ifndef SYNTH
`define BDQ_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bdq assertion failed");
`define BDQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bdq assertion failed");
`else
`define BDQ_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define BDQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/bdq_pkg.sv
// Shared constants, operation codes and inter-module structs for the
// bounded double-ended queue. No dependencies.
package bdq_pkg;

  localparam int DEPTH    = 1024;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 3;
  localparam int CAP_W    = 11;
  localparam int COUNT_W  = 11;
  localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  // register indexes on the config port
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_REAR  = 3'd1,
    KIND_DEL_FRONT = 3'd2,
    KIND_DEL_REAR  = 3'd3,
    KIND_QUERY     = 3'd4
  } kind_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] front_addr;
    logic [IDX_W-1:0] rear_addr;
  } rd_req_t;

  typedef struct packed {
    logic             ok;
    logic             empty;
    logic             full;
    logic [CNT_W-1:0] count;
  } status_t;

endpackage

FILE: rtl/bdq_ctrl.sv
// Pointer and count state of the queue, plus the per-request decode that
// produces the store write, the read addresses and the status. Uses bdq_pkg.
module bdq_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [bdq_pkg::KIND_W-1:0]    kind,
  input  logic [bdq_pkg::DATA_W-1:0]    value,
  input  logic [bdq_pkg::CAP_W-1:0]     capacity,
  output bdq_pkg::wr_req_t              wr,
  output bdq_pkg::rd_req_t              rd,
  output bdq_pkg::status_t              sts,
  output logic                          is_idle
);
  import bdq_pkg::*;

  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             full_cur;
  logic             empty_cur;
  logic             ok;
  logic             we;
  logic [IDX_W-1:0] waddr;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
  endfunction

  // capacity above DEPTH saturates; zero capacity reads as always full
  function automatic logic is_at_limit(input logic [CNT_W-1:0] c,
                                       input logic [CAP_W-1:0] cap);
    return (CMP_W'(c) >= CMP_W'(cap)) || (c == CNT_W'(DEPTH));
  endfunction

  assign full_cur  = is_at_limit(cnt, capacity);
  assign empty_cur = (cnt == '0);
  assign is_idle   = empty_cur;

  always_comb begin
    head_next = head;
    tail_next = tail;
    cnt_next  = cnt;
    ok        = 1'b0;
    we        = 1'b0;
    waddr     = tail;
    unique case (kind_t'(kind))
      KIND_INS_FRONT: begin
        if (!full_cur) begin
          head_next = idx_dec(head);
          waddr     = head_next;
          we        = 1'b1;
          cnt_next  = cnt + CNT_W'(1);
          ok        = 1'b1;
        end
      end
      KIND_INS_REAR: begin
        if (!full_cur) begin
          waddr     = tail;
          tail_next = idx_inc(tail);
          we        = 1'b1;
          cnt_next  = cnt + CNT_W'(1);
          ok        = 1'b1;
        end
      end
      KIND_DEL_FRONT: begin
        if (!empty_cur) begin
          head_next = idx_inc(head);
          cnt_next  = cnt - CNT_W'(1);
          ok        = 1'b1;
        end
      end
      KIND_DEL_REAR: begin
        if (!empty_cur) begin
          tail_next = idx_dec(tail);
          cnt_next  = cnt - CNT_W'(1);
          ok        = 1'b1;
        end
      end
      KIND_QUERY: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign wr.we    = step && we;
  assign wr.addr  = waddr;
  assign wr.data  = value;

  assign rd.front_addr = head_next;
  assign rd.rear_addr  = idx_dec(tail_next);

  assign sts.ok    = ok;
  assign sts.empty = (cnt_next == '0);
  assign sts.full  = is_at_limit(cnt_next, capacity);
  assign sts.count = cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      cnt  <= '0;
    end else if (step) begin
      head <= head_next;
      tail <= tail_next;
      cnt  <= cnt_next;
    end
  end

endmodule

FILE: rtl/bdq_store.sv
// Ring storage: one write port and two registered read ports (front and
// rear), with forwarding of a write that lands on a read address. Uses bdq_pkg.
module bdq_store (
  input  logic                        clk,
  input  logic                        rd_en,
  input  bdq_pkg::wr_req_t            wr,
  input  bdq_pkg::rd_req_t            rd,
  output logic [bdq_pkg::DATA_W-1:0]  front_data,
  output logic [bdq_pkg::DATA_W-1:0]  rear_data
);
  import bdq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] front_raw;
  logic [DATA_W-1:0] rear_raw;
  logic [DATA_W-1:0] wdata;
  logic              front_hit;
  logic              rear_hit;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // reads see the old word; the same-edge write is forwarded instead
  always_ff @(posedge clk) begin
    if (rd_en) begin
      front_raw <= mem[rd.front_addr];
      rear_raw  <= mem[rd.rear_addr];
      front_hit <= wr.we && (wr.addr == rd.front_addr);
      rear_hit  <= wr.we && (wr.addr == rd.rear_addr);
      wdata     <= wr.data;
    end
  end

  assign front_data = front_hit ? wdata : front_raw;
  assign rear_data  = rear_hit  ? wdata : rear_raw;

endmodule

FILE: rtl/bounded_double_ended_queue.sv
// Bounded double-ended queue on a ring buffer of DEPTH words.
// Requests pass through the request register and then the result register; the
// result register loads together with the ring memory read data.
// Throughput: one request per cycle while out_stall does not hold a valid result,
// set by the pointer update and the registered two-port read of the ring memory.
// Reset: pointers and count clear to zero, capacity to 1024; memory not cleared.
module bounded_double_ended_queue (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [bdq_pkg::KIND_W-1:0]           kind,
  input  logic signed [bdq_pkg::DATA_W-1:0]    value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 ok,
  output logic signed [bdq_pkg::DATA_W-1:0]    front_value,
  output logic signed [bdq_pkg::DATA_W-1:0]    rear_value,
  output logic                                 is_empty,
  output logic                                 is_full,
  output logic [bdq_pkg::COUNT_W-1:0]          count,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bdq_pkg::PADDR_W-1:0]          paddr,
  input  logic [bdq_pkg::PDATA_W-1:0]          pwdata,
  output logic [bdq_pkg::PDATA_W-1:0]          prdata,
  output logic                                 pready
);
  import bdq_pkg::*;

  `include "bounded_double_ended_queue_macros.svh"

  logic              v1;
  logic [KIND_W-1:0] kind_r;
  logic [DATA_W-1:0] value_r;
  logic              v2;
  logic              ok_r;
  logic              empty_r;
  logic              full_r;
  logic [CNT_W-1:0]  count_r;
  logic [CAP_W-1:0]  capacity;
  logic              advance;
  logic              step;
  logic              q_idle;
  logic              cfg_wr;
  logic [DATA_W-1:0] front_data;
  logic [DATA_W-1:0] rear_data;
  wr_req_t           wr;
  rd_req_t           rd;
  status_t           sts;

  assign advance  = !v2 || !out_stall;
  assign step     = v1 && advance;
  assign in_stall = v1 && !advance;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (!in_stall) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      kind_r  <= kind;
      value_r <= value;
    end
  end

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .kind     (kind_r),
    .value    (value_r),
    .capacity (capacity),
    .wr       (wr),
    .rd       (rd),
    .sts      (sts),
    .is_idle  (q_idle)
  );

  bdq_store u_store (
    .clk        (clk),
    .rd_en      (advance),
    .wr         (wr),
    .rd         (rd),
    .front_data (front_data),
    .rear_data  (rear_data)
  );

  // result register, loaded together with the memory read data
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ok_r    <= sts.ok;
      empty_r <= sts.empty;
      full_r  <= sts.full;
      count_r <= sts.count;
    end
  end

  assign out_valid   = v2;
  assign ok          = ok_r;
  assign front_value = empty_r ? '1 : front_data;
  assign rear_value  = empty_r ? '1 : rear_data;
  assign is_empty    = empty_r;
  assign is_full     = full_r;
  assign count       = COUNT_W'(count_r);

  // config port; capacity only changes while the queue is empty
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr && (paddr[PADDR_W-1] == REG_CAPACITY) && q_idle) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[PADDR_W-1] == REG_CAPACITY) ? PDATA_W'(capacity) : '0;

  `BDQ_ASSERT_NEXT(a_stalled_req_kept, clk, rst, v1 && in_stall, v1)
  `BDQ_ASSERT_SAME(a_count_bounded, clk, rst, v2, count_r <= CNT_W'(DEPTH))
  `BDQ_ASSERT_SAME(a_empty_not_full, clk, rst, v2 && empty_r && (capacity != '0), !full_r)
  `BDQ_ASSERT_SAME(a_empty_zero_count, clk, rst, v2 && empty_r, count_r == '0)

endmodule
